/* sv/rc6_block_cipher_macros.svh */
// Assertion macros shared by the RC6 checker.
`ifndef RC6_BLOCK_CIPHER_MACROS_SVH
`define RC6_BLOCK_CIPHER_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define RC6_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check on clk that also holds through reset.
`define RC6_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rc6_pkg.sv */
// Types, constants and word functions for the RC6 block cipher.
package rc6_pkg;

  typedef logic [31:0] word_t;

  localparam int DEF_ROUNDS        = 20;
  localparam int DEF_MAX_KEY_BYTES = 32;

  localparam word_t SEED_P = 32'hB7E15163;
  localparam word_t SEED_Q = 32'h9E3779B9;

  localparam int KEY_REG_W   = 64;
  localparam int NUM_KEY_REG = 4;
  localparam int KEY_LEN_W   = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int BLOCK_W     = 128;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  function automatic word_t rol32(input word_t x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic word_t ror32(input word_t x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // rol(x * (2x + 1), 5)
  function automatic word_t rc6_f(input word_t x);
    word_t m;
    m = x * {x[30:0], 1'b1};
    return {m[26:0], m[31:27]};
  endfunction

endpackage

/* sv/rc6_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rc6_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rc6_block_cipher.sv */
// RC6-32 block cipher top level: key expansion sequencer and round datapath.
//
// Input channel in_*: one word is a 128-bit block (A in the low 32 bits) plus
// in_tuser, the opcode (0 encrypt, 1 decrypt). Output channel out_*: one word
// with the four transformed block words, A lowest.
// Config port cfg_*: key bytes in registers 0..3, key length in register 4;
// any write to those marks the round key table stale.
// Each round and each whitening step runs in an even, an odd and an apply
// phase, because the multiplier is shared and the round key RAM has a single
// read port. If the table is stale, key expansion runs first; its shared
// add/rotate unit does one half of a mixing step each cycle.
// in_tready is high only while no block is in flight. A finished result sits
// in the output register; the next block is taken and worked on meanwhile
// and waits at its end until that register is free.
// Reset clears the key registers (length 16), drops out_tvalid and marks the
// table stale; no clearing pass is needed.
module rc6_block_cipher
  import rc6_pkg::*;
#(
  parameter int ROUNDS        = DEF_ROUNDS,
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BLOCK_W-1:0]   in_tdata,   // in_word_a, in_word_b, in_word_c, in_word_d
  input  logic [0:0]           in_tuser,   // opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BLOCK_W-1:0]   out_tdata,  // out_word_a, out_word_b, out_word_c, out_word_d
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_REG_W-1:0] cfg_data
);

  localparam int NUM_RK    = 2 * ROUNDS + 4;
  localparam int NUM_KW    = (MAX_KEY_BYTES + 3) / 4;
  localparam int AW        = $clog2(NUM_RK);
  localparam int RW        = $clog2(ROUNDS + 2);
  localparam int KJ_W      = (NUM_KW > 1) ? $clog2(NUM_KW) : 1;
  localparam int CW        = $clog2(NUM_KW + 1);
  localparam int STEP_BASE = (NUM_KW > NUM_RK) ? NUM_KW : NUM_RK;
  localparam int STEP_W    = $clog2(3 * STEP_BASE);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_CIPHER = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic [1:0] PH_EVEN  = 2'd0;
  localparam logic [1:0] PH_ODD   = 2'd1;
  localparam logic [1:0] PH_APPLY = 2'd2;

  // control
  logic [1:0]          state_r, state_nxt;
  logic                keys_ready_r, keys_ready_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic [RW-1:0]       j_r, j_nxt;
  logic                xph_r, xph_nxt;
  logic                first_r, first_nxt;
  logic [AW-1:0]       ri_r, ri_nxt;
  logic [KJ_W-1:0]     kj_r, kj_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [STEP_W-1:0]   steps_last_r, steps_last_nxt;
  logic [CW-1:0]       c_r, c_nxt;

  // configuration
  logic [KEY_REG_W-1:0] key_r [NUM_KEY_REG];
  logic [KEY_REG_W-1:0] key_nxt [NUM_KEY_REG];
  logic [KEY_LEN_W-1:0] key_len_r, key_len_nxt;

  // datapath
  word_t               kw_r [NUM_KW];
  word_t               kw_nxt [NUM_KW];
  word_t               ea_r, ea_nxt, eb_r, eb_nxt, seed_r, seed_nxt;
  word_t               wa_r, wa_nxt, wb_r, wb_nxt, wc_r, wc_nxt, wd_r, wd_nxt;
  word_t               t_r, t_nxt, u_r, u_nxt, k_r, k_nxt;
  logic                op_r, op_nxt;
  logic [BLOCK_W-1:0]  out_data_r, out_data_nxt;

  // round key RAM
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  word_t               ram_rdata;

  // expansion load values
  logic [KEY_LEN_W-1:0] nb;
  logic [CW-1:0]        c_load;
  logic [STEP_W-1:0]    steps_last_load;
  word_t                kw_load [NUM_KW];
  logic [NUM_KEY_REG*KEY_REG_W-1:0] key_bits;

  // shared add/rotate unit
  word_t               mix_op, mix_ab, mix_sum, mix_res;
  logic [4:0]          mix_amt;

  // shared multiplier for t and u
  word_t               f_in, f_res;

  // cipher addressing
  logic [RW-1:0]       e_idx;
  logic [AW-1:0]       addr_even, addr_odd;
  logic                is_pre, is_post;
  word_t               ko;

  rc6_ram #(
    .WIDTH (32),
    .DEPTH (NUM_RK)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ri_r),
    .wdata (mix_res),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // key words, word count and mixing step count from the current key
  always_comb begin
    int mx;
    key_bits = {key_r[3], key_r[2], key_r[1], key_r[0]};
    nb = (key_len_r > KEY_LEN_W'(MAX_KEY_BYTES)) ? KEY_LEN_W'(MAX_KEY_BYTES) : key_len_r;
    if (nb == '0) begin
      c_load = CW'(1);
    end else begin
      c_load = CW'(({1'b0, nb} + 7'd3) >> 2);
    end
    for (int k = 0; k < NUM_KW; k++) begin
      for (int m = 0; m < 4; m++) begin
        if (4 * k + m < int'(nb)) begin
          kw_load[k][8*m +: 8] = key_bits[8*(4*k+m) +: 8];
        end else begin
          kw_load[k][8*m +: 8] = 8'h00;
        end
      end
    end
    mx = (int'(c_load) > NUM_RK) ? int'(c_load) : NUM_RK;
    steps_last_load = STEP_W'(3 * mx - 1);
  end

  // phase 0 updates a round key, phase 1 a key word
  assign mix_op  = xph_r ? kw_r[kj_r] : (first_r ? seed_r : ram_rdata);
  assign mix_ab  = ea_r + eb_r;
  assign mix_sum = mix_op + mix_ab;
  assign mix_amt = xph_r ? mix_ab[4:0] : 5'd3;
  assign mix_res = rol32(mix_sum, mix_amt);

  // t from the even phase, u from the odd phase
  assign f_in  = (ph_r == PH_EVEN) ? ((op_r == OP_DECRYPT) ? wa_r : wb_r)
                                   : ((op_r == OP_DECRYPT) ? wc_r : wd_r);
  assign f_res = rc6_f(f_in);

  // decrypt walks the key table from the top; whitening uses the end pairs
  assign e_idx     = (op_r == OP_DECRYPT) ? (RW'(ROUNDS + 1) - j_r) : j_r;
  assign addr_even = AW'({e_idx, 1'b0});
  assign addr_odd  = AW'({e_idx, 1'b1});
  assign is_pre    = (j_r == '0);
  assign is_post   = (j_r == RW'(ROUNDS + 1));
  assign ko        = ram_rdata;

  always_comb begin
    if (state_r == ST_EXPAND) begin
      ram_raddr = ri_r;
    end else if (ph_r == PH_EVEN) begin
      ram_raddr = addr_even;
    end else begin
      ram_raddr = addr_odd;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    keys_ready_nxt = keys_ready_r;
    out_valid_nxt  = out_valid_r;
    ph_nxt         = ph_r;
    j_nxt          = j_r;
    xph_nxt        = xph_r;
    first_nxt      = first_r;
    ri_nxt         = ri_r;
    kj_nxt         = kj_r;
    step_nxt       = step_r;
    steps_last_nxt = steps_last_r;
    c_nxt          = c_r;
    key_nxt        = key_r;
    key_len_nxt    = key_len_r;
    kw_nxt         = kw_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    seed_nxt       = seed_r;
    wa_nxt         = wa_r;
    wb_nxt         = wb_r;
    wc_nxt         = wc_r;
    wd_nxt         = wd_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    k_nxt          = k_r;
    op_nxt         = op_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
          key_nxt[cfg_index[1:0]] = cfg_data;
          keys_ready_nxt          = 1'b0;
        end
        REG_KEY_LEN: begin
          key_len_nxt    = cfg_data[KEY_LEN_W-1:0];
          keys_ready_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          wa_nxt = in_tdata[31:0];
          wb_nxt = in_tdata[63:32];
          wc_nxt = in_tdata[95:64];
          wd_nxt = in_tdata[127:96];
          op_nxt = in_tuser[0];
          j_nxt  = '0;
          ph_nxt = PH_EVEN;
          if (keys_ready_r) begin
            state_nxt = ST_CIPHER;
          end else begin
            kw_nxt         = kw_load;
            c_nxt          = c_load;
            steps_last_nxt = steps_last_load;
            seed_nxt       = SEED_P;
            ri_nxt         = '0;
            kj_nxt         = '0;
            ea_nxt         = '0;
            eb_nxt         = '0;
            first_nxt      = 1'b1;
            step_nxt       = '0;
            xph_nxt        = 1'b0;
            state_nxt      = ST_EXPAND;
          end
        end
      end

      ST_EXPAND: begin
        if (!xph_r) begin
          ram_we   = 1'b1;
          ea_nxt   = mix_res;
          seed_nxt = seed_r + SEED_Q;
          if (ri_r == AW'(NUM_RK - 1)) begin
            ri_nxt    = '0;
            first_nxt = 1'b0;
          end else begin
            ri_nxt = ri_r + AW'(1);
          end
          xph_nxt = 1'b1;
        end else begin
          kw_nxt[kj_r] = mix_res;
          eb_nxt       = mix_res;
          if (int'(kj_r) + 1 == int'(c_r)) begin
            kj_nxt = '0;
          end else begin
            kj_nxt = kj_r + KJ_W'(1);
          end
          xph_nxt  = 1'b0;
          step_nxt = step_r + STEP_W'(1);
          if (step_r == steps_last_r) begin
            keys_ready_nxt = 1'b1;
            state_nxt      = ST_CIPHER;
          end
        end
      end

      ST_CIPHER: begin
        case (ph_r)
          PH_EVEN: begin
            t_nxt  = f_res;
            ph_nxt = PH_ODD;
          end
          PH_ODD: begin
            u_nxt  = f_res;
            k_nxt  = ram_rdata;
            ph_nxt = PH_APPLY;
          end
          PH_APPLY: begin
            // k_r holds the even key of the pair, ko the odd one
            if (op_r == OP_ENCRYPT) begin
              if (is_pre) begin
                wb_nxt = wb_r + k_r;
                wd_nxt = wd_r + ko;
              end else if (is_post) begin
                wa_nxt = wa_r + k_r;
                wc_nxt = wc_r + ko;
              end else begin
                wa_nxt = wb_r;
                wb_nxt = rol32(wc_r ^ u_r, t_r[4:0]) + ko;
                wc_nxt = wd_r;
                wd_nxt = rol32(wa_r ^ t_r, u_r[4:0]) + k_r;
              end
            end else begin
              if (is_pre) begin
                wa_nxt = wa_r - k_r;
                wc_nxt = wc_r - ko;
              end else if (is_post) begin
                wb_nxt = wb_r - k_r;
                wd_nxt = wd_r - ko;
              end else begin
                wa_nxt = ror32(wd_r - k_r, u_r[4:0]) ^ t_r;
                wb_nxt = wa_r;
                wc_nxt = ror32(wb_r - ko, t_r[4:0]) ^ u_r;
                wd_nxt = wc_r;
              end
            end
            ph_nxt = PH_EVEN;
            j_nxt  = j_r + RW'(1);
            if (is_post) begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            ph_nxt = PH_EVEN;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {wd_r, wc_r, wb_r, wa_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      ph_r         <= PH_EVEN;
      j_r          <= '0;
      xph_r        <= 1'b0;
      first_r      <= 1'b0;
      ri_r         <= '0;
      kj_r         <= '0;
      step_r       <= '0;
      steps_last_r <= '0;
      c_r          <= '0;
      for (int i = 0; i < NUM_KEY_REG; i++) begin
        key_r[i] <= '0;
      end
      key_len_r    <= KEY_LEN_W'(16);
    end else begin
      state_r      <= state_nxt;
      keys_ready_r <= keys_ready_nxt;
      out_valid_r  <= out_valid_nxt;
      ph_r         <= ph_nxt;
      j_r          <= j_nxt;
      xph_r        <= xph_nxt;
      first_r      <= first_nxt;
      ri_r         <= ri_nxt;
      kj_r         <= kj_nxt;
      step_r       <= step_nxt;
      steps_last_r <= steps_last_nxt;
      c_r          <= c_nxt;
      key_r        <= key_nxt;
      key_len_r    <= key_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kw_r       <= kw_nxt;
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    seed_r     <= seed_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    wc_r       <= wc_nxt;
    wd_r       <= wd_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    k_r        <= k_nxt;
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* sv/rc6_checker.sv */
// Port-level checks for the RC6 block cipher, bound to the top level.
`include "rc6_block_cipher_macros.svh"

module rc6_checker
  import rc6_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [BLOCK_W-1:0] out_tdata
);

  // a stalled result word stays up
  `RC6_ASSERT(a_out_hold_valid, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped under stall")

  // and its data does not change
  `RC6_ASSERT(a_out_hold_data, out_tvalid && !out_tready |=> $stable(out_tdata), "out_tdata changed under stall")

  // one block in flight at a time
  `RC6_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "in_tready high right after accept")

  // reset leaves the block empty and ready
  `RC6_ASSERT_NORST(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "block not idle after reset")

endmodule

bind rc6_block_cipher rc6_checker u_rc6_checker (.*);
